// ===== sv/cdq_pkg.sv =====
package cdq_pkg;

  typedef enum logic [1:0] {
    REQ_ADD  = 2'd0,
    REQ_DEL  = 2'd1,
    REQ_TICK = 2'd2,
    REQ_NONE = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_EXPIRED = 2'd2,
    ST_NOTHING = 2'd3
  } status_e;

  localparam logic REG_WAIT = 1'b0;
  localparam logic REG_KICK = 1'b1;

  localparam logic [15:0] WAIT_RESET = 16'd20;
  localparam logic [15:0] WAIT_MIN   = 16'd1;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_INS_RD  = 8'b0000_0010,
    S_INS     = 8'b0000_0100,
    S_INS_PUT = 8'b0000_1000,
    S_DEL     = 8'b0001_0000,
    S_TK_RD   = 8'b0010_0000,
    S_TK_CHK  = 8'b0100_0000,
    S_SPARE   = 8'b1000_0000
  } state_e;

endpackage

// ===== sv/connection_deadline_queue.sv =====
// Channel  Handshake                         Payload
// request  start_i accepted when !busy_o     req_type_i now_time_i conn_id_i conn_sequence_i
// result   result_valid_o, one cycle each    status_o expired_conn_o expired_sequence_o
//                                            removed_count_o occupancy_o last_o
// config   APB write, pready always high     pwdata (wait_time at 0, kick_on_expiry at 4)
//
// An item without queue work has its result on the ports in the cycle after it is accepted.
// An add walks down from the tail, moving each later-deadline entry up one slot; a delete
// walks every held entry, keeping the rest packed. A tick pops expired head entries, and a
// re-armed one redoes the add walk. The memory does one read and one write a cycle.
// Reset clears the control state only; no clearing pass runs over the memory.
module connection_deadline_queue #(
  parameter int QUEUE_DEPTH = 64,
  parameter int CONN_BITS   = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  output logic                                   busy_o,
  input  cdq_pkg::req_e                          req_type_i,
  input  logic [31:0]                            now_time_i,
  input  logic [CONN_BITS-1:0]                   conn_id_i,
  input  logic [31:0]                            conn_sequence_i,
  output logic                                   result_valid_o,
  output cdq_pkg::status_e                       status_o,
  output logic [CONN_BITS-1:0]                   expired_conn_o,
  output logic [31:0]                            expired_sequence_o,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]       removed_count_o,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]       occupancy_o,
  output logic                                   last_o,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [2:0]                             paddr,
  input  logic [31:0]                            pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);
  import cdq_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int EW = 64 + CONN_BITS;

  logic [EW-1:0]        mem_q [QUEUE_DEPTH];
  logic [EW-1:0]        rd_data_q;
  logic                 mem_we;
  logic [AW-1:0]        mem_wa;
  logic [AW-1:0]        mem_ra;
  logic [EW-1:0]        mem_wd;

  state_e               state_q, state_d;
  logic [CW-1:0]        count_q, count_d;
  logic [AW-1:0]        head_q, head_d;
  logic [AW-1:0]        cur_q, cur_d;
  logic [CW-1:0]        wr_q, wr_d;
  logic [CW-1:0]        rem_q, rem_d;
  logic [CW-1:0]        budget_q, budget_d;
  logic                 first_q, first_d;
  logic                 ins_tick_q, ins_tick_d;
  logic [31:0]          ins_dl_q, ins_dl_d;
  logic [CONN_BITS-1:0] ins_own_q, ins_own_d;
  logic [31:0]          ins_seq_q, ins_seq_d;
  logic [31:0]          now_q, now_d;
  logic [CONN_BITS-1:0] conn_q, conn_d;
  logic [15:0]          wait_q;
  logic                 kick_q;

  logic                 rv_q, rv_d;
  status_e              status_q, status_d;
  logic [CONN_BITS-1:0] xconn_q, xconn_d;
  logic [31:0]          xseq_q, xseq_d;
  logic [CW-1:0]        xrem_q, xrem_d;
  logic [CW-1:0]        occ_q, occ_d;
  logic                 last_q, last_d;

  logic                 accept;
  logic                 ins_done;
  logic [31:0]          rd_dl;
  logic [CONN_BITS-1:0] rd_own;
  logic [31:0]          rd_seq;
  logic [CW-1:0]        cnt_m1;
  logic                 tick_hit;
  logic                 cfg_we;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [AW-1:0] li);
    logic [AW:0] s;
    s = {1'b0, head} + {1'b0, li};
    if (s >= (AW+1)'(QUEUE_DEPTH)) begin
      s = s - (AW+1)'(QUEUE_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  function automatic logic [31:0] sat_dl(input logic [31:0] now, input logic [15:0] w);
    logic [32:0] s;
    s = {1'b0, now} + {17'b0, w};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  assign busy_o  = (state_q != S_IDLE);
  assign accept  = start_i && !busy_o;
  assign rd_dl   = rd_data_q[EW-1 -: 32];
  assign rd_own  = rd_data_q[32 +: CONN_BITS];
  assign rd_seq  = rd_data_q[31:0];
  assign cnt_m1  = count_q - CW'(1);
  assign tick_hit = first_q ? (rd_dl < now_q) : (rd_dl <= now_q);

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    head_d     = head_q;
    cur_d      = cur_q;
    wr_d       = wr_q;
    rem_d      = rem_q;
    budget_d   = budget_q;
    first_d    = first_q;
    ins_tick_d = ins_tick_q;
    ins_dl_d   = ins_dl_q;
    ins_own_d  = ins_own_q;
    ins_seq_d  = ins_seq_q;
    now_d      = now_q;
    conn_d     = conn_q;
    rv_d       = 1'b0;
    status_d   = status_q;
    xconn_d    = xconn_q;
    xseq_d     = xseq_q;
    xrem_d     = xrem_q;
    occ_d      = occ_q;
    last_d     = last_q;
    mem_we     = 1'b0;
    mem_wa     = phys(head_q, cur_q);
    mem_wd     = {ins_dl_q, ins_own_q, ins_seq_q};
    mem_ra     = phys(head_q, '0);
    ins_done   = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          rv_d     = 1'b0;
          status_d = ST_DONE;
          xconn_d  = '0;
          xseq_d   = '0;
          xrem_d   = '0;
          occ_d    = count_q;
          last_d   = 1'b1;
          case (req_type_i)
            REQ_ADD: begin
              if (count_q == CW'(QUEUE_DEPTH)) begin
                rv_d     = 1'b1;
                status_d = ST_FULL;
              end else begin
                ins_dl_d   = sat_dl(now_time_i, wait_q);
                ins_own_d  = conn_id_i;
                ins_seq_d  = conn_sequence_i;
                ins_tick_d = 1'b0;
                state_d    = S_INS_RD;
              end
            end
            REQ_DEL: begin
              if (count_q == '0) begin
                rv_d = 1'b1;
              end else begin
                conn_d  = conn_id_i;
                cur_d   = '0;
                wr_d    = '0;
                rem_d   = '0;
                state_d = S_DEL;
              end
            end
            REQ_TICK: begin
              if (count_q == '0) begin
                rv_d     = 1'b1;
                status_d = ST_NOTHING;
              end else begin
                now_d    = now_time_i;
                budget_d = count_q;
                first_d  = 1'b1;
                state_d  = S_TK_CHK;
              end
            end
            default: begin
              rv_d = 1'b1;
            end
          endcase
        end
      end
      S_INS_RD: begin
        if (count_q == '0) begin
          mem_we   = 1'b1;
          mem_wa   = phys(head_q, '0);
          ins_done = 1'b1;
        end else begin
          mem_ra  = phys(head_q, cnt_m1[AW-1:0]);
          cur_d   = cnt_m1[AW-1:0];
          state_d = S_INS;
        end
      end
      S_INS: begin
        mem_we = 1'b1;
        mem_wa = phys(head_q, cur_q + AW'(1));
        if (rd_dl > ins_dl_q) begin
          mem_wd = rd_data_q;
          if (cur_q == '0) begin
            state_d = S_INS_PUT;
          end else begin
            mem_ra = phys(head_q, cur_q - AW'(1));
            cur_d  = cur_q - AW'(1);
          end
        end else begin
          ins_done = 1'b1;
        end
      end
      S_INS_PUT: begin
        mem_we   = 1'b1;
        mem_wa   = phys(head_q, '0);
        ins_done = 1'b1;
      end
      S_DEL: begin
        mem_ra = phys(head_q, cur_q + AW'(1));
        if (rd_own == conn_q) begin
          rem_d = rem_q + CW'(1);
        end else begin
          mem_we = 1'b1;
          mem_wa = phys(head_q, wr_q[AW-1:0]);
          mem_wd = rd_data_q;
          wr_d   = wr_q + CW'(1);
        end
        if (CW'(cur_q) + CW'(1) == count_q) begin
          count_d  = wr_d;
          rv_d     = 1'b1;
          status_d = ST_DONE;
          xconn_d  = '0;
          xseq_d   = '0;
          xrem_d   = rem_d;
          occ_d    = wr_d;
          last_d   = 1'b1;
          state_d  = S_IDLE;
        end else begin
          cur_d = cur_q + AW'(1);
        end
      end
      S_TK_RD: begin
        if (budget_q == '0 || count_q == '0) begin
          rv_d     = 1'b1;
          status_d = ST_EXPIRED;
          xconn_d  = ins_own_q;
          xseq_d   = ins_seq_q;
          xrem_d   = '0;
          occ_d    = count_q;
          last_d   = 1'b1;
          state_d  = S_IDLE;
        end else begin
          state_d = S_TK_CHK;
        end
      end
      S_TK_CHK: begin
        xrem_d = '0;
        occ_d  = count_q;
        if (!tick_hit) begin
          rv_d    = 1'b1;
          last_d  = 1'b1;
          state_d = S_IDLE;
          if (first_q) begin
            status_d = ST_NOTHING;
            xconn_d  = '0;
            xseq_d   = '0;
          end else begin
            status_d = ST_EXPIRED;
            xconn_d  = ins_own_q;
            xseq_d   = ins_seq_q;
          end
        end else begin
          if (!first_q) begin
            rv_d     = 1'b1;
            status_d = ST_EXPIRED;
            xconn_d  = ins_own_q;
            xseq_d   = ins_seq_q;
            last_d   = 1'b0;
          end
          head_d    = phys(head_q, AW'(1));
          count_d   = cnt_m1;
          budget_d  = budget_q - CW'(1);
          ins_own_d = rd_own;
          ins_seq_d = rd_seq;
          first_d   = 1'b0;
          if (kick_q) begin
            state_d = S_TK_RD;
          end else begin
            ins_dl_d   = sat_dl(now_q, wait_q);
            ins_tick_d = 1'b1;
            state_d    = S_INS_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (ins_done) begin
      count_d = count_q + CW'(1);
      if (ins_tick_q) begin
        state_d = S_TK_RD;
      end else begin
        rv_d     = 1'b1;
        status_d = ST_DONE;
        xconn_d  = '0;
        xseq_d   = '0;
        xrem_d   = '0;
        occ_d    = count_q + CW'(1);
        last_d   = 1'b1;
        state_d  = S_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    rd_data_q <= mem_q[mem_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      head_q     <= '0;
      cur_q      <= '0;
      wr_q       <= '0;
      rem_q      <= '0;
      budget_q   <= '0;
      first_q    <= 1'b0;
      ins_tick_q <= 1'b0;
      rv_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      head_q     <= head_d;
      cur_q      <= cur_d;
      wr_q       <= wr_d;
      rem_q      <= rem_d;
      budget_q   <= budget_d;
      first_q    <= first_d;
      ins_tick_q <= ins_tick_d;
      rv_q       <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ins_dl_q  <= ins_dl_d;
    ins_own_q <= ins_own_d;
    ins_seq_q <= ins_seq_d;
    now_q     <= now_d;
    conn_q    <= conn_d;
    status_q  <= status_d;
    xconn_q   <= xconn_d;
    xseq_q    <= xseq_d;
    xrem_q    <= xrem_d;
    occ_q     <= occ_d;
    last_q    <= last_d;
  end

  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wait_q <= WAIT_RESET;
      kick_q <= 1'b0;
    end else if (cfg_we) begin
      if (paddr[2] == REG_WAIT) begin
        wait_q <= (pwdata[15:0] == '0) ? WAIT_MIN : pwdata[15:0];
      end else begin
        kick_q <= pwdata[0];
      end
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_KICK) ? {31'b0, kick_q} : {16'b0, wait_q};

  assign result_valid_o     = rv_q;
  assign status_o           = status_q;
  assign expired_conn_o     = xconn_q;
  assign expired_sequence_o = xseq_q;
  assign removed_count_o    = xrem_q;
  assign occupancy_o        = occ_q;
  assign last_o             = last_q;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(QUEUE_DEPTH))
    else $error("entry count exceeds queue depth");

  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy_o || result_valid_o))
    else $error("accepted item produced neither work nor result");

  a_full_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o == ST_FULL) |-> (occupancy_o == CW'(QUEUE_DEPTH)))
    else $error("full status with queue not full");

  a_idle_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_o) |-> busy_o)
    else $error("block idle after a result that was not last");
`endif

endmodule
